/* hw/rtl/adpcm_frame_decoder_core_defines.svh */
// Assertion macros shared by the decoder RTL files.
`ifndef ADPCM_FRAME_DECODER_CORE_DEFINES_SVH
`define ADPCM_FRAME_DECODER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every clock edge outside reset.
`define AFD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("afd assertion failed");

// Condition that must never hold outside reset.
`define AFD_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("afd forbidden condition seen");

`else

`define AFD_ASSERT(lbl, prop)
`define AFD_ASSERT_NEVER(lbl, cond)

`endif

`endif

/* hw/rtl/afd_pkg.sv */
// Types and constants for the ADPCM frame decoder.
package afd_pkg;

   localparam int NumPairs       = 8;
   localparam int PairIdxW       = 3;
   localparam int FrameDataBytes = 7;
   localparam int ScaleBias      = 11;
   localparam int RoundBias      = 1024;
   localparam int SampleMin      = -32768;
   localparam int SampleMax      = 32767;
   localparam int AccW           = 34;

   // Command codes on the request channel.
   localparam logic CMD_STREAM = 1'b0;
   localparam logic CMD_LOAD   = 1'b1;

   typedef enum logic {
      OP_DATA = 1'b0,
      OP_LOAD = 1'b1
   } afd_op_kind_type;

   // One queued operation for the back end.
   typedef struct packed {
      afd_op_kind_type       kind;
      logic [7:0]            byte_val;
      logic [3:0]            scale;
      logic [PairIdxW-1:0]   pair;
      logic                  bad;
      logic [15:0]           hist_newer;
      logic [15:0]           hist_older;
   } afd_op_type;

   // Queue status seen by the back end.
   typedef struct packed {
      logic       empty;
      afd_op_type head;
   } afd_q_status_type;

endpackage

/* hw/rtl/afd_ifs.sv */
// Channel interfaces: request, response and register write.
interface afd_req_if
   import afd_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               command;
   logic [7:0]         byte_in;
   logic signed [15:0] start_newer;
   logic signed [15:0] start_older;

   modport source (output valid, command, byte_in, start_newer, start_older, input ready);
   modport sink   (input valid, command, byte_in, start_newer, start_older, output ready);
endinterface

interface afd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               second_of_byte;
   logic               bad_pair;

   modport source (output valid, sample, second_of_byte, bad_pair, input ready);
   modport sink   (input valid, sample, second_of_byte, bad_pair, output ready);
endinterface

interface afd_csr_if
   import afd_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [PairIdxW-1:0] index;
   logic [31:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/afd_fifo.sv */
// Short operation queue between the front and back ends.
`include "adpcm_frame_decoder_core_defines.svh"

module afd_fifo
   import afd_pkg::*;
#(
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  afd_op_type       push_op,
   output logic             full,
   input  logic             pop,
   output afd_q_status_type status
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   afd_op_type        slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full         = (count_ff == FullCnt);
   assign status.empty = (count_ff == '0);
   assign status.head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   `AFD_ASSERT_NEVER(a_fifo_overflow, push && full && !pop)
   `AFD_ASSERT_NEVER(a_fifo_underflow, pop && status.empty)
   `AFD_ASSERT(a_fifo_count_up, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))

endmodule

/* hw/rtl/afd_front.sv */
// Front end: accepts request items, decodes headers, queues work.
module afd_front
   import afd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   afd_req_if.sink     req,
   input  logic        full,
   output logic        push,
   output afd_op_type  push_op
);

   logic [2:0] pos_ff, pos_in;
   logic [3:0] scale_ff, scale_in;
   logic [3:0] pair_ff, pair_in;
   logic       accept;

   assign req.ready = !full;
   assign accept    = req.valid && req.ready;

   always_comb begin
      pos_in   = pos_ff;
      scale_in = scale_ff;
      pair_in  = pair_ff;
      push     = 1'b0;

      push_op.kind       = OP_DATA;
      push_op.byte_val   = req.byte_in;
      push_op.scale      = scale_ff;
      push_op.pair       = pair_ff[PairIdxW-1:0];
      push_op.bad        = pair_ff[3];
      push_op.hist_newer = req.start_newer;
      push_op.hist_older = req.start_older;

      if (req.command == CMD_LOAD) begin
         push_op.kind = OP_LOAD;
      end

      if (accept) begin
         if (req.command == CMD_LOAD) begin
            push   = 1'b1;
            pos_in = '0;
         end else if (pos_ff == '0) begin
            // header: scale in low nibble, pair in high nibble
            scale_in = req.byte_in[3:0];
            pair_in  = req.byte_in[7:4];
            pos_in   = 3'd1;
         end else begin
            push   = 1'b1;
            pos_in = (pos_ff == 3'(FrameDataBytes)) ? '0 : pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         scale_ff <= '0;
         pair_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         scale_ff <= scale_in;
         pair_ff  <= pair_in;
      end
   end

endmodule

/* hw/rtl/afd_back.sv */
// Back end: predicts samples, keeps history, drives the response register.
`include "adpcm_frame_decoder_core_defines.svh"

module afd_back
   import afd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  afd_q_status_type status,
   output logic             pop,
   input  logic [31:0]      coef_pairs [NumPairs],
   afd_rsp_if.source        rsp
);

   logic signed [15:0] hist_newer_ff, hist_newer_in;
   logic signed [15:0] hist_older_ff, hist_older_in;
   logic               nib_sel_ff, nib_sel_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] sample_ff;
   logic               second_ff;
   logic               bad_ff;

   afd_op_type         head;
   logic               is_load;
   logic               out_free;
   logic               issue;
   logic [3:0]         nib;
   logic [31:0]        coef;
   logic signed [31:0] prod_n;
   logic signed [31:0] prod_o;
   logic signed [AccW-1:0] nib_ext;
   logic signed [AccW-1:0] scaled;
   logic signed [AccW-1:0] sum;
   logic signed [AccW-1:0] shifted;
   logic signed [15:0] sample_val;
   logic [4:0]         shamt;

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.sample         = sample_ff;
   assign rsp.second_of_byte = second_ff;
   assign rsp.bad_pair       = bad_ff;

   always_comb begin
      head     = status.head;
      is_load  = (head.kind == OP_LOAD);
      out_free = !rsp_valid_ff || rsp.ready;
      issue    = !status.empty && !is_load && out_free;
      // a data op leaves the queue with its low-nibble sample
      pop      = !status.empty && (is_load || (out_free && nib_sel_ff));

      nib    = nib_sel_ff ? head.byte_val[3:0] : head.byte_val[7:4];
      coef   = head.bad ? '0 : coef_pairs[head.pair];
      prod_n = 32'($signed(coef[15:0])) * 32'(hist_newer_ff);
      prod_o = 32'($signed(coef[31:16])) * 32'(hist_older_ff);

      nib_ext = {{(AccW-4){nib[3]}}, nib};
      shamt   = {1'b0, head.scale} + 5'(ScaleBias);
      scaled  = nib_ext <<< shamt;
      sum     = scaled + {{(AccW-32){prod_n[31]}}, prod_n}
                       + {{(AccW-32){prod_o[31]}}, prod_o}
                       + AccW'(RoundBias);
      shifted = sum >>> ScaleBias;

      if (shifted < AccW'(SampleMin)) begin
         sample_val = 16'sh8000;
      end else if (shifted > AccW'(SampleMax)) begin
         sample_val = 16'sh7fff;
      end else begin
         sample_val = shifted[15:0];
      end

      hist_newer_in = hist_newer_ff;
      hist_older_in = hist_older_ff;
      if (!status.empty && is_load) begin
         hist_newer_in = head.hist_newer;
         hist_older_in = head.hist_older;
      end else if (issue) begin
         hist_older_in = hist_newer_ff;
         hist_newer_in = sample_val;
      end

      nib_sel_in   = issue ? !nib_sel_ff : nib_sel_ff;
      rsp_valid_in = issue ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_newer_ff <= '0;
         hist_older_ff <= '0;
         nib_sel_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hist_newer_ff <= hist_newer_in;
         hist_older_ff <= hist_older_in;
         nib_sel_ff    <= nib_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         sample_ff <= sample_val;
         second_ff <= nib_sel_ff;
         bad_ff    <= head.bad;
      end
   end

   `AFD_ASSERT_NEVER(a_data_pop_on_low, pop && !is_load && !nib_sel_ff)
   `AFD_ASSERT(a_hist_shift, issue |=> (hist_older_ff == $past(hist_newer_ff)))
   `AFD_ASSERT(a_low_then_high, (issue && nib_sel_ff) |=> !nib_sel_ff)

endmodule

/* hw/rtl/adpcm_frame_decoder_core.sv */
// Top level of the 4-bit ADPCM frame decoder.
//
//  channel   dir  handshake     payload
//  req_ch    in   valid/ready   command, byte_in, start_newer, start_older
//  rsp_ch    out  valid/ready   sample, second_of_byte, bad_pair
//  csr_ch    in   valid/ready   index (coef pair 0..7), data (32 bit)
//
// The sample unit decodes a data byte one nibble at a time, high nibble first,
// feeding each sample back through the two 16x16 multipliers. Header items
// never reach the back end; load-history items only set the history. Results
// appear in the cycle after their computation, from the response register.
// Reset is synchronous, active high; it clears frame position, header,
// history, queue and coefficient registers. No clearing pass is needed.
// The front accepts items while the queue has room, so a stalled response
// side backs up through the queue before req_ch.ready drops.
`include "adpcm_frame_decoder_core_defines.svh"

module adpcm_frame_decoder_core
   import afd_pkg::*;
#(
   parameter int QueueDepth = 2
) (
   input  logic     clock,
   input  logic     reset,
   afd_req_if.sink  req_ch,
   afd_rsp_if.source rsp_ch,
   afd_csr_if.sink  csr_ch
);

   logic [31:0]      coef_pair_ff [NumPairs];
   logic             push;
   afd_op_type       push_op;
   logic             full;
   logic             pop;
   afd_q_status_type q_status;

   // Coefficient registers; writes are always taken.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumPairs; i++) begin
            coef_pair_ff[i] <= '0;
         end
      end else if (csr_ch.valid) begin
         coef_pair_ff[csr_ch.index] <= csr_ch.data;
      end
   end

   // Front: header decode and frame position.
   afd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .full    (full),
      .push    (push),
      .push_op (push_op)
   );

   // Queue decoupling the two sides.
   afd_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .full    (full),
      .pop     (pop),
      .status  (q_status)
   );

   // Back: sample prediction and response register.
   afd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (q_status),
      .pop        (pop),
      .coef_pairs (coef_pair_ff),
      .rsp        (rsp_ch)
   );

   `AFD_ASSERT(a_csr_write, csr_ch.valid |=> (coef_pair_ff[$past(csr_ch.index)] == $past(csr_ch.data)))
   `AFD_ASSERT_NEVER(a_push_when_full, push && full && !pop)
   `AFD_ASSERT(a_ready_tracks_full, req_ch.ready == !full)

endmodule
